@@ rtl/tcc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the text console cursor engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
package tcc_pkg;

  // Font size: codes at or above this value draw the replacement glyph.
  localparam int unsigned GLYPH_COUNT = 128;
  // Default tab stop spacing handed to the top level parameter.
  localparam int unsigned TAB_WIDTH_DEF = 4;

  // Character codes the cursor logic reacts to.
  localparam logic [7:0] CHAR_BS        = 8'h08;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_QMARK     = 8'h3F;
  localparam logic [7:0] CHAR_PRINT_MIN = 8'h20;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd4;

  // Input opcodes.
  typedef enum logic {
    OP_PUT   = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // Result commands.
  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // One input beat.
  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  glyph;
    logic [7:0]  cell_column;
    logic [7:0]  cell_row;
    logic [31:0] ink;
    logic [31:0] paper;
    logic        last;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic        enabled;
    logic [7:0]  column_count;
    logic [7:0]  row_count;
    logic [31:0] foreground_color;
    logic [31:0] background_color;
  } cfg_t;

endpackage

@@ rtl/tcc_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file of the text console cursor engine.
// Depends on tcc_pkg for the register indexes and the cfg_t layout.
module tcc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data,
  output tcc_pkg::cfg_t                     cfg
);

  tcc_pkg::cfg_t cfg_r;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register write decode; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled          <= 1'b0;
      cfg_r.column_count     <= 8'd1;
      cfg_r.row_count        <= 8'd1;
      cfg_r.foreground_color <= 32'h00FF_FFFF;
      cfg_r.background_color <= 32'h0000_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcc_pkg::CFG_ENABLED:    cfg_r.enabled          <= cfg_data[0];
        tcc_pkg::CFG_COLUMNS:    cfg_r.column_count     <= cfg_data[7:0];
        tcc_pkg::CFG_ROWS:       cfg_r.row_count        <= cfg_data[7:0];
        tcc_pkg::CFG_FOREGROUND: cfg_r.foreground_color <= cfg_data;
        tcc_pkg::CFG_BACKGROUND: cfg_r.background_color <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/tcc_step.sv @@
`timescale 1ns / 1ps
// Combinational cursor step: one result beat and the next cursor per cycle.
// Depends on tcc_pkg for codes, commands and the item and config types.
module tcc_step #(
  parameter int unsigned TAB_WIDTH = tcc_pkg::TAB_WIDTH_DEF,
  parameter int unsigned PHASE_W   = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1
) (
  input  tcc_pkg::in_item_t  item,
  input  tcc_pkg::cfg_t      cfg,
  input  logic [7:0]         col,
  input  logic [7:0]         row,
  input  logic [PHASE_W-1:0] phase,
  input  logic               pend_scroll,
  output logic               emit,
  output logic               done,
  output tcc_pkg::out_item_t res,
  output logic [7:0]         col_nxt,
  output logic [7:0]         row_nxt,
  output logic [PHASE_W-1:0] phase_nxt,
  output logic               pend_nxt
);

  localparam logic [PHASE_W-1:0] PHASE_TOP = PHASE_W'(TAB_WIDTH - 1);

  logic [7:0]         eff_cols;
  logic [7:0]         eff_rows;
  logic [8:0]         col_inc;
  logic               wrap;
  logic               bottom;
  logic [7:0]         lf_row;
  logic [PHASE_W-1:0] phase_inc;
  logic [PHASE_W-1:0] phase_dec;
  logic [7:0]         glyph_sel;

  // A size of zero behaves as one.
  assign eff_cols = (cfg.column_count == 8'd0) ? 8'd1 : cfg.column_count;
  assign eff_rows = (cfg.row_count == 8'd0) ? 8'd1 : cfg.row_count;

  // Advance and line feed conditions.
  assign col_inc = {1'b0, col} + 9'd1;
  assign wrap    = (col_inc >= {1'b0, eff_cols});
  assign bottom  = (({1'b0, row} + 9'd1) >= {1'b0, eff_rows});
  assign lf_row  = bottom ? (eff_rows - 8'd1) : (row + 8'd1);

  // Column position within the current tab stop, kept incrementally.
  assign phase_inc = (phase == PHASE_TOP) ? '0 : (phase + PHASE_W'(1));
  assign phase_dec = (phase == '0) ? PHASE_TOP : (phase - PHASE_W'(1));

  // Codes outside the font draw a question mark.
  assign glyph_sel = ({1'b0, item.char_code} >= 9'(tcc_pkg::GLYPH_COUNT)) ?
                     tcc_pkg::CHAR_QMARK : item.char_code;

  always_comb begin
    emit            = 1'b0;
    done            = 1'b1;
    pend_nxt        = 1'b0;
    col_nxt         = col;
    row_nxt         = row;
    phase_nxt       = phase;
    res.command     = tcc_pkg::CMD_DRAW;
    res.glyph       = 8'd0;
    res.cell_column = 8'd0;
    res.cell_row    = 8'd0;
    res.ink         = 32'd0;
    res.paper       = cfg.background_color;
    res.last        = 1'b1;

    if (pend_scroll) begin
      // Second beat of a draw that wrapped off the bottom row.
      emit        = 1'b1;
      res.command = tcc_pkg::CMD_SCROLL;
    end else if (item.opcode == tcc_pkg::OP_CLEAR) begin
      emit        = 1'b1;
      res.command = tcc_pkg::CMD_CLEAR;
      col_nxt     = 8'd0;
      row_nxt     = 8'd0;
      phase_nxt   = '0;
    end else if (cfg.enabled) begin
      unique case (item.char_code)
        tcc_pkg::CHAR_LF: begin
          col_nxt   = 8'd0;
          phase_nxt = '0;
          row_nxt   = lf_row;
          if (bottom) begin
            emit        = 1'b1;
            res.command = tcc_pkg::CMD_SCROLL;
          end
        end
        tcc_pkg::CHAR_CR: begin
          col_nxt   = 8'd0;
          phase_nxt = '0;
        end
        tcc_pkg::CHAR_BS: begin
          if (col != 8'd0) begin
            emit            = 1'b1;
            col_nxt         = col - 8'd1;
            phase_nxt       = phase_dec;
            res.glyph       = tcc_pkg::CHAR_SPACE;
            res.cell_column = col - 8'd1;
            res.cell_row    = row;
            res.ink         = cfg.foreground_color;
          end
        end
        default: begin
          // Tab and printable codes draw at the cursor and then advance.
          if (item.char_code == tcc_pkg::CHAR_TAB ||
              item.char_code >= tcc_pkg::CHAR_PRINT_MIN) begin
            emit            = 1'b1;
            res.glyph       = (item.char_code == tcc_pkg::CHAR_TAB) ?
                              tcc_pkg::CHAR_SPACE : glyph_sel;
            res.cell_column = col;
            res.cell_row    = row;
            res.ink         = cfg.foreground_color;
            if (wrap) begin
              col_nxt   = 8'd0;
              phase_nxt = '0;
              row_nxt   = lf_row;
              if (bottom) begin
                pend_nxt = 1'b1;
                done     = 1'b0;
              end
            end else begin
              col_nxt   = col_inc[7:0];
              phase_nxt = phase_inc;
              // A tab keeps drawing blanks until the next stop.
              if (item.char_code == tcc_pkg::CHAR_TAB && phase_inc != '0) begin
                done = 1'b0;
              end
            end
            res.last = done;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/text_console_cursor_engine_core.sv @@
`timescale 1ns / 1ps
// Top level of the text console cursor engine: item register, cursor state,
// result register. Depends on tcc_pkg, tcc_cfg_regs and tcc_step.
//
// Usage:
//   The in_ channel takes one beat per character or clear request. The out_
//   channel gives cell-level commands (draw glyph, scroll up, clear), with
//   last set on the final beat caused by an input beat. The cfg_ channel
//   writes the five registers by index and is always ready; write it only
//   while the engine is idle.
//   An input beat is registered in the item register, stepped
//   combinationally, and its result is registered in the result register.
//   Throughput: one result beat per cycle out of the single step stage
//   unless out_ready stalls the result register. A tab draws blanks up to
//   the next stop or the row end, at most TAB_WIDTH, plus a scroll when it
//   wraps off the bottom row; a printable character that wraps off the
//   bottom row gives a draw, then a scroll.
//   A new input beat is accepted in the cycle its predecessor finishes.
//   When out_ready is low the result register holds; the item register
//   keeps one more beat, then in_ready drops until results drain.
//   Reset clears the cursor to the home cell, drops all pending beats and
//   loads the register defaults (console disabled, 1x1 screen).
module text_console_cursor_engine_core #(
  parameter int unsigned TAB_WIDTH = tcc_pkg::TAB_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tcc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tcc_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int unsigned PHASE_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

  tcc_pkg::cfg_t      cfg;
  tcc_pkg::in_item_t  item_r;
  logic               item_valid_r;
  logic [7:0]         col_r;
  logic [7:0]         row_r;
  logic [PHASE_W-1:0] phase_r;
  logic               pend_r;
  logic               out_valid_r;
  tcc_pkg::out_item_t out_r;

  logic               step_emit;
  logic               step_done;
  tcc_pkg::out_item_t step_res;
  logic [7:0]         col_nxt;
  logic [7:0]         row_nxt;
  logic [PHASE_W-1:0] phase_nxt;
  logic               pend_nxt;
  logic               can_emit;
  logic               fire;
  logic               item_done;

  // Configuration registers.
  tcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Cursor step logic between the item register and the result register.
  tcc_step #(
    .TAB_WIDTH (TAB_WIDTH),
    .PHASE_W   (PHASE_W)
  ) u_step (
    .item        (item_r),
    .cfg         (cfg),
    .col         (col_r),
    .row         (row_r),
    .phase       (phase_r),
    .pend_scroll (pend_r),
    .emit        (step_emit),
    .done        (step_done),
    .res         (step_res),
    .col_nxt     (col_nxt),
    .row_nxt     (row_nxt),
    .phase_nxt   (phase_nxt),
    .pend_nxt    (pend_nxt)
  );

  // A step commits when its result beat, if any, has room.
  assign can_emit  = !out_valid_r || out_ready;
  assign fire      = item_valid_r && (!step_emit || can_emit);
  assign item_done = fire && step_done;
  assign in_ready  = !item_valid_r || item_done;

  // Item register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid_r <= 1'b1;
    end else if (item_done) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  // Cursor state and the pending scroll flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= 8'd0;
      row_r   <= 8'd0;
      phase_r <= '0;
      pend_r  <= 1'b0;
    end else if (fire) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_emit) begin
      out_valid_r <= fire && step_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit && fire && step_emit) begin
      out_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A pending scroll always belongs to an item still held.
  assert property (@(posedge clk) disable iff (!rst_n) pend_r |-> item_valid_r)
    else $error("pending scroll without an item");

  // A pending scroll follows a wrap, so the cursor sits at column zero.
  assert property (@(posedge clk) disable iff (!rst_n) pend_r |-> (col_r == 8'd0))
    else $error("pending scroll with cursor off column zero");

  // The tab phase tracks the column: column zero is a tab stop.
  assert property (@(posedge clk) disable iff (!rst_n) (col_r == 8'd0) |-> (phase_r == '0))
    else $error("tab phase out of step with column");

  // The final beat of an item reaches the result register marked last.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (fire && step_emit && step_done) |=> (out_valid_r && out_r.last))
    else $error("final result beat not marked last");

endmodule
